// ----- rtl/power_of_two_modulo_assert.svh -----
// ----------------------------------------------------------------------------
// power_of_two_modulo_assert.svh
// Assertion macros for the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef POWER_OF_TWO_MODULO_ASSERT_SVH
`define POWER_OF_TWO_MODULO_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("ptm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("ptm assertion failed");

`endif

// ----- rtl/ptm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_pkg
// Request and result types and the controller-to-datapath interface.
// ----------------------------------------------------------------------------
package ptm_pkg;

	localparam int FIELD_BITS = 64;

	typedef struct packed {
		logic [FIELD_BITS-1:0] exponent;
		logic [FIELD_BITS-1:0] modulus;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] remainder;
		logic                  bad_modulus;
	} out_item_t;

	typedef struct packed {
		logic load;       // capture the request
		logic init;       // result = 1, base = 2 mod m
		logic mul_start;  // clear accumulator, pick operands
		logic sel_sq;     // 1: squaring of the base, 0: result times base
		logic dbl;        // accumulator doubled modulo m
		logic add;        // conditional add of the multiplicand, multiplier shift
		logic wb;         // write the finished product back
		logic shift_e;    // move to the next exponent bit
		logic out_load;   // load the output register
	} dp_cmd_t;

	typedef struct packed {
		logic special;    // modulus is zero or one
		logic ebit;       // current exponent bit
	} dp_status_t;

endpackage

// ----- rtl/ptm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_ctrl
// Sequencer for square-and-multiply and the double-and-add products inside it.
// ----------------------------------------------------------------------------
module ptm_ctrl import ptm_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam int CW = $clog2(WORD_BITS);
	localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_EBIT  = 8'b0000_0100,
		S_SQ    = 8'b0000_1000,
		S_DBL   = 8'b0001_0000,
		S_ADD   = 8'b0010_0000,
		S_WB    = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t          state_q, state_d;
	logic [CW-1:0]   ecnt_q, mcnt_q;
	logic            sel_sq_q;
	logic            out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sel_sq = sel_sq_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.init = 1'b1;
				state_d  = status.special ? S_DONE : S_EBIT;
			end
			S_EBIT: begin
				if (status.ebit) begin
					cmd.mul_start = 1'b1;
					cmd.sel_sq    = 1'b0;
					state_d       = S_DBL;
				end else begin
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				cmd.mul_start = 1'b1;
				cmd.sel_sq    = 1'b1;
				state_d       = S_DBL;
			end
			S_DBL: begin
				cmd.dbl = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = (mcnt_q == LAST) ? S_WB : S_DBL;
			end
			S_WB: begin
				cmd.wb = 1'b1;
				if (sel_sq_q) begin
					cmd.shift_e = 1'b1;
					state_d     = (ecnt_q == LAST) ? S_DONE : S_EBIT;
				end else begin
					state_d = S_SQ;
				end
			end
			S_DONE: begin
				// The finished result waits here until the output slot is free.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ecnt_q      <= '0;
			mcnt_q      <= '0;
			sel_sq_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.init)
				ecnt_q <= '0;
			else if (cmd.shift_e)
				ecnt_q <= ecnt_q + 1'b1;
			if (cmd.mul_start) begin
				mcnt_q   <= '0;
				sel_sq_q <= cmd.sel_sq;
			end else if (cmd.add) begin
				mcnt_q <= mcnt_q + 1'b1;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/ptm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_datapath
// Operand registers and one shared modular adder for double-and-add products.
// ----------------------------------------------------------------------------
module ptm_datapath import ptm_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic       clk,
	input  in_item_t   in_data,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output out_item_t  out_data
);

	localparam int W = WORD_BITS;

	logic [W-1:0] exp_q, mod_q, res_q, base_q, acc_q, a_q, b_q;
	logic [W-1:0] addend;
	logic [W:0]   sum, diff;
	logic [W-1:0] sum_mod;
	logic         bad, special;
	out_item_t    out_q;

	// Both operands are below the modulus, so one conditional subtract reduces.
	assign addend  = cmd.dbl ? acc_q : a_q;
	assign sum     = {1'b0, acc_q} + {1'b0, addend};
	assign diff    = sum - {1'b0, mod_q};
	assign sum_mod = (sum >= {1'b0, mod_q}) ? diff[W-1:0] : sum[W-1:0];

	assign bad     = (mod_q == '0);
	assign special = bad || (mod_q == W'(1));

	assign status.special = special;
	assign status.ebit    = exp_q[0];
	assign out_data       = out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			exp_q <= in_data.exponent[W-1:0];
			mod_q <= in_data.modulus[W-1:0];
		end else if (cmd.shift_e) begin
			exp_q <= exp_q >> 1;
		end

		if (cmd.init) begin
			res_q  <= W'(1);
			base_q <= (mod_q == W'(2)) ? '0 : W'(2);
		end else if (cmd.wb) begin
			if (cmd.sel_sq)
				base_q <= acc_q;
			else
				res_q <= acc_q;
		end

		if (cmd.mul_start) begin
			acc_q <= '0;
			a_q   <= cmd.sel_sq ? base_q : res_q;
			b_q   <= base_q;
		end else if (cmd.dbl) begin
			acc_q <= sum_mod;
		end else if (cmd.add) begin
			if (b_q[W-1])
				acc_q <= sum_mod;
			b_q <= b_q << 1;
		end

		if (cmd.out_load) begin
			out_q.remainder   <= special ? '0 : FIELD_BITS'(res_q);
			out_q.bad_modulus <= bad;
		end
	end

endmodule

// ----- rtl/power_of_two_modulo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_of_two_modulo
// Two raised to an exponent, reduced by a modulus, by square-and-multiply.
// ----------------------------------------------------------------------------
// Usage: a request (exponent, modulus) enters on in_valid/in_ready and one
// result (remainder, bad_modulus) leaves on out_valid/out_ready. Only the low
// WORD_BITS bits of each request field are used.
// One request is worked on at a time; in_ready is high only while the block
// waits for a request. A zero or unit modulus answers 0 without any
// multiplication, with bad_modulus set for a zero modulus.
// Otherwise each exponent bit, lowest first, costs a squaring of the base and,
// when the bit is set, a product of result and base before it; all WORD_BITS
// exponent bits are worked. The pace is set by the single shared
// modular adder, which does one doubling or one conditional add per cycle.
// Results sit in an output register: a new request is taken while a result
// still waits there, and a finished result waits inside the block while the
// receiver stalls. Reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module power_of_two_modulo import ptm_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	ptm_ctrl #(
		.WORD_BITS(WORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ptm_datapath #(
		.WORD_BITS(WORD_BITS)
	) u_datapath (
		.clk     (clk),
		.in_data (in_data),
		.cmd     (cmd),
		.status  (status),
		.out_data(out_data)
	);

endmodule

// ----- rtl/ptm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_checker
// Port-level checks on the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "power_of_two_modulo_assert.svh"

module ptm_checker import ptm_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	logic [FIELD_BITS-1:0] high_bits;

	// Bits of the remainder above the datapath width.
	assign high_bits = out_data.remainder >> WORD_BITS;

	`PTM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`PTM_ASSERT_NOW(a_bad_zero, clk, arst_n, out_valid && out_data.bad_modulus, out_data.remainder == '0)
	`PTM_ASSERT_NOW(a_rem_width, clk, arst_n, out_valid, high_bits == '0)
	`PTM_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind power_of_two_modulo ptm_checker #(.WORD_BITS(WORD_BITS)) u_checker (.*);

// ----- dv/tb_power_of_two_modulo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_of_two_modulo
// Self-checking bench for the power-of-two modular exponentiation block.
// ----------------------------------------------------------------------------
// A table of directed requests covers zero and unit moduli, a zero exponent,
// the field extremes and a few hand-checkable powers. Random requests follow.
// Each accepted request queues its expected result, which is either typed
// into the table or computed by an exact 128-bit square-and-multiply. Results
// are compared in order, field by field. The sender works in bursts, the
// receiver stalls on shifting patterns, and one long receiver hold-off
// backs the block up until it stops taking requests.
// ----------------------------------------------------------------------------
module tb_power_of_two_modulo;
	import ptm_pkg::*;

	localparam int WORD_BITS = 64;
	localparam logic [63:0] WORD_MASK = (WORD_BITS == 64) ? '1 : ((64'd1 << WORD_BITS) - 1);
	localparam int RANDOM_REQUESTS = 80;
	localparam int HOLD_AFTER = 20;
	localparam int HOLD_CYCLES = 70000;
	localparam int WATCHDOG_LIMIT = 250000;
	localparam int DRAIN_CYCLES = 50;

	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t want;
	} directed_row_t;

	typedef struct {
		in_item_t  req;
		out_item_t want;
	} pending_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	directed_row_t directed_rows[$];
	pending_t      pending_results[$];
	int            mismatch_count = 0;
	int            idle_cycles = 0;

	power_of_two_modulo #(
		.WORD_BITS(WORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Exact products at double width, so no reduction ever overflows.
	function automatic out_item_t pow2_mod(in_item_t req);
		logic [63:0]  e;
		logic [63:0]  m;
		logic [63:0]  acc;
		logic [63:0]  sq;
		logic [127:0] prod;
		out_item_t    r;
		e = req.exponent & WORD_MASK;
		m = req.modulus & WORD_MASK;
		r.remainder = '0;
		r.bad_modulus = (m == 64'd0);
		if (m > 64'd1) begin
			acc = 64'd1;
			sq = 64'd2 % m;
			for (int i = 0; i < WORD_BITS; i++) begin
				if (e[i]) begin
					prod = ({64'd0, acc} * {64'd0, sq}) % {64'd0, m};
					acc = prod[63:0];
				end
				prod = ({64'd0, sq} * {64'd0, sq}) % {64'd0, m};
				sq = prod[63:0];
			end
			r.remainder = acc;
		end
		return r;
	endfunction

	task automatic add_row(logic [63:0] e, logic [63:0] m, bit typed, logic [63:0] rem,
			logic bad);
		directed_row_t row;
		row.req.exponent = e;
		row.req.modulus = m;
		row.typed = typed;
		row.want.remainder = rem;
		row.want.bad_modulus = bad;
		directed_rows.push_back(row);
	endtask

	function automatic in_item_t random_request();
		in_item_t req;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			req.modulus = 64'd0;
		else if (pick < 10)
			req.modulus = 64'd1;
		else if (pick < 25)
			req.modulus = 64'($urandom_range(2, 65535));
		else if (pick < 35)
			req.modulus = 64'd1 << $urandom_range(1, 63);
		else if (pick < 40)
			req.modulus = '1 - 64'($urandom_range(0, 255));
		else
			req.modulus = {$urandom, $urandom};
		if ($urandom_range(0, 4) == 0)
			req.exponent = 64'($urandom_range(0, 130));
		else
			req.exponent = {$urandom, $urandom};
		return req;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_result(out_item_t got);
		pending_t p;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result remainder=%h bad_modulus=%b",
				got.remainder, got.bad_modulus));
			return;
		end
		p = pending_results.pop_front();
		if (got.remainder !== p.want.remainder)
			report_mismatch($sformatf("e=%h m=%h remainder got %h want %h",
				p.req.exponent, p.req.modulus, got.remainder, p.want.remainder));
		if (got.bad_modulus !== p.want.bad_modulus)
			report_mismatch($sformatf("e=%h m=%h bad_modulus got %b want %b",
				p.req.exponent, p.req.modulus, got.bad_modulus, p.want.bad_modulus));
	endtask

	// Holds valid and data until the request is taken, then queues its result.
	task automatic send_request(in_item_t req, bit typed, out_item_t want,
			inout int burst_left);
		pending_t p;
		int       gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p.req = req;
		p.want = typed ? want : pow2_mod(req);
		pending_results.push_back(p);
		burst_left--;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Result side: checks each accepted result, then picks the next ready value.
	initial begin : result_side
		int  mode;
		int  tick;
		int  got_count;
		bit  held;
		bit  rdy;
		mode = 0;
		tick = 0;
		got_count = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				check_result(out_data);
				got_count++;
			end
			tick++;
			if (tick % 64 == 0)
				mode = $urandom_range(0, 3);
			if (!held && got_count == HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			case (mode)
				0: rdy = 1'b1;
				1: rdy = ($urandom_range(0, 1) == 1);
				2: rdy = (tick % 4 == 0);
				default: rdy = ($urandom_range(0, 3) == 0);
			endcase
			out_ready <= rdy;
		end
	end

	initial begin : request_side
		int        burst_left;
		out_item_t none;
		burst_left = 0;
		none = '0;

		add_row(64'd0, 64'd0, 1'b1, 64'd0, 1'b1);
		add_row('1, 64'd0, 1'b1, 64'd0, 1'b1);
		add_row(64'd5, 64'd1, 1'b1, 64'd0, 1'b0);
		add_row('1, 64'd1, 1'b1, 64'd0, 1'b0);
		add_row(64'd0, '1, 1'b1, 64'd1, 1'b0);
		add_row(64'd0, 64'd2, 1'b1, 64'd1, 1'b0);
		add_row(64'd1, 64'd2, 1'b1, 64'd0, 1'b0);
		add_row(64'd1, '1, 1'b1, 64'd2, 1'b0);
		add_row(64'd10, 64'd1000, 1'b1, 64'd24, 1'b0);
		add_row(64'd63, '1, 1'b1, 64'h8000_0000_0000_0000, 1'b0);
		add_row(64'd64, '1, 1'b1, 64'd1, 1'b0);
		add_row(64'd100, 64'h8000_0000_0000_0000, 1'b1, 64'd0, 1'b0);
		add_row('1, '1, 1'b0, '0, 1'b0);
		add_row('1, 64'd3, 1'b0, '0, 1'b0);
		add_row(64'd62, 64'h8000_0000_0000_0001, 1'b0, '0, 1'b0);
		add_row('1, 64'h8000_0000_0000_0001, 1'b0, '0, 1'b0);
		add_row(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0, 1'b0);
		add_row(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0, '0, 1'b0);
		add_row(64'd1_000_000_006, 64'd1_000_000_007, 1'b0, '0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want,
				burst_left);
		for (int n = 0; n < RANDOM_REQUESTS; n++)
			send_request(random_request(), 1'b0, none, burst_left);
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
